>>> rtl/rlg_pkg.sv
// Shared constants, types and the sigmoid lookup table for the ranking gradient engine.
package rlg_pkg;

   localparam int MAX_SAMPLES  = 64;
   localparam int MAX_FEATURES = 16;
   localparam int MAX_PAIRS    = 256;
   localparam int OUT_LIMIT    = 16;
   localparam int NF_LIMIT     = (MAX_FEATURES < OUT_LIMIT) ? MAX_FEATURES : OUT_LIMIT;

   localparam int SAMP_W  = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
   localparam int FEAT_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int PAIR_AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int MAT_D   = MAX_SAMPLES * MAX_FEATURES;
   localparam int MAT_AW  = (MAT_D > 1) ? $clog2(MAT_D) : 1;
   localparam int SCNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int FCNT_W  = $clog2(NF_LIMIT + 1);
   localparam int PCNT_W  = $clog2(MAX_PAIRS + 1);

   // Field widths of the channels.
   localparam int CMD_W   = 3;
   localparam int SIDX_W  = 6;
   localparam int FIDX_W  = 4;
   localparam int VAL_W   = 16;
   localparam int GRAD_W  = 32;
   localparam int STAT_W  = 2;
   localparam int CSR_IW  = 1;
   localparam int CSR_DW  = 7;
   localparam int NS_W    = 7;
   localparam int NF_W    = 5;
   localparam int PENT_W  = 2 * SIDX_W;

   // Datapath widths.
   localparam int SPROD_W = 2 * VAL_W;
   localparam int SCORE_W = 40;
   localparam int WSUM_W  = 32;
   localparam int GPROD_W = WSUM_W + VAL_W;
   localparam int GACC_W  = 56;
   localparam int FRAC_SH = 12;
   localparam int DIV_W   = GACC_W - FRAC_SH;
   localparam int DCNT_W  = $clog2(DIV_W + 1);
   localparam int REM_W   = PCNT_W + 1;
   localparam int TAB_W   = 17;
   localparam int DIFF_W  = SCORE_W + 1;

   localparam logic [CMD_W-1:0] CMD_LOAD_MATRIX = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_WEIGHT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ADD_PAIR    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR_PAIRS = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RUN         = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_NO_PAIRS = 2'd1;
   localparam logic [STAT_W-1:0] ST_DROPPED  = 2'd2;

   localparam logic [CSR_IW-1:0] CSR_NUM_SAMPLES  = 1'd0;
   localparam logic [CSR_IW-1:0] CSR_NUM_FEATURES = 1'd1;

   typedef struct packed {
      logic               idle;
      logic [MAT_AW-1:0]  mat_addr;
      logic [FEAT_W-1:0]  wv_idx;
      logic [SAMP_W-1:0]  samp_idx;
      logic [PAIR_AW-1:0] pair_addr;
      logic               first;
      logic               score_mul;
      logic               score_acc;
      logic               score_wr;
      logic               pair_latch;
      logic               rd_sel_a;
      logic               rd_sel_b;
      logic               sa_latch;
      logic               t_calc;
      logic               wr_a;
      logic               wr_b;
      logic               used_inc;
      logic               g_mul;
      logic               g_acc;
      logic               div_init;
      logic               div_step;
      logic               out_load;
      logic [FEAT_W-1:0]  out_feature;
      logic               out_last;
   } ctl_cmd_type;

   typedef struct packed {
      logic              run_start;
      logic [SCNT_W-1:0] ns;
      logic [FCNT_W-1:0] nf;
      logic [PCNT_W-1:0] pair_count;
      logic              pair_ok;
      logic              out_free;
   } ctl_stat_type;

   typedef logic [TAB_W-1:0] sig_tab_type [256];

   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] a0, a1, b0, b1, p00, p01, p10, p11, mid, lo, hi;
      a0  = {32'd0, a[31:0]};
      a1  = {32'd0, a[63:32]};
      b0  = {32'd0, b[31:0]};
      b1  = {32'd0, b[63:32]};
      p00 = a0 * b0;
      p01 = a0 * b1;
      p10 = a1 * b0;
      p11 = a1 * b1;
      mid = (p00 >> 32) + {32'd0, p01[31:0]} + {32'd0, p10[31:0]};
      lo  = {mid[31:0], p00[31:0]};
      hi  = p11 + (p01 >> 32) + (p10 >> 32) + (mid >> 32);
      return (hi << 2) | (lo >> 62);
   endfunction

   // Unsigned quotient by shift and subtract; used only while building the table.
   function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q, r;
      q = '0;
      r = '0;
      for (int k = 63; k >= 0; k--) begin
         r = {r[62:0], num[k]};
         if (r >= den) begin
            r    = r - den;
            q[k] = 1'b1;
         end
      end
      return q;
   endfunction

   // Sigmoid at the positive bin centre (2m+1)/32, Q0.16, rounded.
   function automatic logic [TAB_W-1:0] sigmoid_pos(input int m);
      logic [63:0] y, s, term, dp, q;
      y    = 64'(2 * m + 1) << 54;
      s    = 64'd1 << 62;
      term = 64'd1 << 62;
      for (int n = 1; n <= 30; n++) begin
         term = div_u64(mul_q62(term, y), 64'(n));
         if ((n & 1) == 1) begin
            s = s - term;
         end else begin
            s = s + term;
         end
      end
      for (int n = 0; n < 3; n++) begin
         s = mul_q62(s, s);
      end
      dp = ((64'd1 << 62) + s) >> 22;
      q  = (div_u64(64'd1 << 57, dp) + 64'd1) >> 1;
      return q[TAB_W-1:0];
   endfunction

   function automatic sig_tab_type build_sig_tab();
      sig_tab_type t;
      logic [TAB_W-1:0] v;
      for (int m = 0; m < 128; m++) begin
         v = sigmoid_pos(m);
         t[128 + m] = v;
         t[127 - m] = TAB_W'(65536) - v;
      end
      return t;
   endfunction

   localparam sig_tab_type SIG_TAB = build_sig_tab();

endpackage

>>> rtl/rlg_if.sv
// Valid/ready channel interfaces for commands, results and register writes.
interface rlg_req_if;
   logic                         valid;
   logic                         ready;
   logic [rlg_pkg::CMD_W-1:0]    cmd;
   logic [rlg_pkg::SIDX_W-1:0]   sample_index;
   logic [rlg_pkg::FIDX_W-1:0]   feature_index;
   logic [rlg_pkg::SIDX_W-1:0]   larger_index;
   logic signed [rlg_pkg::VAL_W-1:0] value;
   modport source (output valid, cmd, sample_index, feature_index, larger_index, value,
                   input ready);
   modport sink (input valid, cmd, sample_index, feature_index, larger_index, value,
                 output ready);
endinterface

interface rlg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rlg_pkg::FIDX_W-1:0]    out_feature;
   logic signed [rlg_pkg::GRAD_W-1:0] gradient;
   logic                          last;
   logic [rlg_pkg::STAT_W-1:0]    status;
   modport source (output valid, out_feature, gradient, last, status, input ready);
   modport sink (input valid, out_feature, gradient, last, status, output ready);
endinterface

interface rlg_csr_if;
   logic                       valid;
   logic                       ready;
   logic [rlg_pkg::CSR_IW-1:0] index;
   logic [rlg_pkg::CSR_DW-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/rlg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rlg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH)-1:0]         waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic [$clog2(DEPTH)-1:0]         raddr,
   output logic [WIDTH-1:0]                 rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

>>> rtl/rlg_datapath.sv
// Stores, registers and arithmetic of the ranking gradient engine.
module rlg_datapath (
   input  logic                  clock,
   input  logic                  reset,
   rlg_req_if.sink               req_bus,
   rlg_rsp_if.source             rsp_bus,
   rlg_csr_if.sink               csr_bus,
   input  rlg_pkg::ctl_cmd_type  cmd,
   output rlg_pkg::ctl_stat_type stat
);
   import rlg_pkg::*;

   logic accept;
   logic [NS_W-1:0] ns_raw_ff, ns_raw_in;
   logic [NF_W-1:0] nf_raw_ff, nf_raw_in;
   logic [SCNT_W-1:0] ns;
   logic [FCNT_W-1:0] nf;

   logic              mat_we;
   logic [MAT_AW-1:0] mat_waddr;
   logic [VAL_W-1:0]  mat_rdata;
   logic signed [VAL_W-1:0] wv_ff [MAX_FEATURES];

   logic               pair_we;
   logic [PENT_W-1:0]  pair_rdata;
   logic [PCNT_W-1:0]  pair_count_ff, pair_count_in;
   logic               dropped_ff, dropped_in;

   logic [SIDX_W-1:0]  a_ff, b_ff;
   logic [SAMP_W-1:0]  samp_raddr, samp_waddr;
   logic [SCORE_W-1:0] score_rdata;
   logic [WSUM_W-1:0]  weight_rdata, weight_wdata, wa_plus_t;
   logic               weight_we;

   logic signed [SPROD_W-1:0] sprod_ff;
   logic signed [SCORE_W-1:0] sacc_ff, sacc_in;
   logic signed [SCORE_W-1:0] sa_ff;
   logic [WSUM_W-1:0]  wa_ff, wb_ff;
   logic [TAB_W-1:0]   t_ff;
   logic signed [DIFF_W-1:0] diff;
   logic [7:0]         tab_idx;
   logic [PCNT_W-1:0]  used_ff;

   logic signed [GPROD_W-1:0] gprod_ff;
   logic signed [GACC_W-1:0]  gacc_ff, gacc_in;
   logic [GACC_W-1:0]  mag;
   logic [DIV_W-1:0]   quot_ff;
   logic [PCNT_W-1:0]  rem_ff;
   logic [REM_W-1:0]   rem_sh;
   logic               rem_ge;
   logic               neg_ff;
   logic [GRAD_W-1:0]  grad_sat;
   logic [STAT_W-1:0]  status_code;

   logic               out_valid_ff;
   logic [FIDX_W-1:0]  out_feature_ff;
   logic [GRAD_W-1:0]  out_grad_ff;
   logic               out_last_ff;
   logic [STAT_W-1:0]  out_status_ff;

   assign req_bus.ready = cmd.idle;
   assign csr_bus.ready = 1'b1;
   assign accept = req_bus.valid && cmd.idle;

   // Configuration registers.
   always_comb begin
      ns_raw_in = ns_raw_ff;
      nf_raw_in = nf_raw_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_NUM_SAMPLES:  ns_raw_in = csr_bus.data[NS_W-1:0];
            CSR_NUM_FEATURES: nf_raw_in = csr_bus.data[NF_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ns_raw_ff <= NS_W'(64);
         nf_raw_ff <= NF_W'(16);
      end else begin
         ns_raw_ff <= ns_raw_in;
         nf_raw_ff <= nf_raw_in;
      end
   end

   always_comb begin
      if (ns_raw_ff == '0) begin
         ns = SCNT_W'(1);
      end else if (32'(ns_raw_ff) > MAX_SAMPLES) begin
         ns = SCNT_W'(MAX_SAMPLES);
      end else begin
         ns = SCNT_W'(ns_raw_ff);
      end
      if (nf_raw_ff == '0) begin
         nf = FCNT_W'(1);
      end else if (32'(nf_raw_ff) > NF_LIMIT) begin
         nf = FCNT_W'(NF_LIMIT);
      end else begin
         nf = FCNT_W'(nf_raw_ff);
      end
   end

   // Matrix store and weight vector loads.
   assign mat_we = accept && (req_bus.cmd == CMD_LOAD_MATRIX)
                   && (32'(req_bus.sample_index) < MAX_SAMPLES)
                   && (32'(req_bus.feature_index) < MAX_FEATURES);
   assign mat_waddr = MAT_AW'(32'(req_bus.sample_index) * MAX_FEATURES
                              + 32'(req_bus.feature_index));

   rlg_ram #(.WIDTH(VAL_W), .DEPTH(MAT_D)) u_mat_ram (
      .clock (clock),
      .we    (mat_we),
      .waddr (mat_waddr),
      .wdata (req_bus.value),
      .raddr (cmd.mat_addr),
      .rdata (mat_rdata)
   );

   always_ff @(posedge clock) begin
      if (accept && (req_bus.cmd == CMD_LOAD_WEIGHT)
          && (32'(req_bus.feature_index) < MAX_FEATURES)) begin
         wv_ff[FEAT_W'(req_bus.feature_index)] <= req_bus.value;
      end
   end

   // Pair store.
   assign pair_we = accept && (req_bus.cmd == CMD_ADD_PAIR)
                    && (32'(pair_count_ff) < MAX_PAIRS);

   always_comb begin
      pair_count_in = pair_count_ff;
      dropped_in    = dropped_ff;
      if (accept && (req_bus.cmd == CMD_ADD_PAIR)) begin
         if (pair_we) begin
            pair_count_in = pair_count_ff + PCNT_W'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end else if (accept && (req_bus.cmd == CMD_CLEAR_PAIRS)) begin
         pair_count_in = '0;
         dropped_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_count_ff <= '0;
         dropped_ff    <= 1'b0;
      end else begin
         pair_count_ff <= pair_count_in;
         dropped_ff    <= dropped_in;
      end
   end

   rlg_ram #(.WIDTH(PENT_W), .DEPTH(MAX_PAIRS)) u_pair_ram (
      .clock (clock),
      .we    (pair_we),
      .waddr (PAIR_AW'(pair_count_ff)),
      .wdata ({req_bus.sample_index, req_bus.larger_index}),
      .raddr (cmd.pair_addr),
      .rdata (pair_rdata)
   );

   // Per-sample score and weight stores.
   always_comb begin
      if (cmd.rd_sel_a) begin
         samp_raddr = SAMP_W'(a_ff);
      end else if (cmd.rd_sel_b) begin
         samp_raddr = SAMP_W'(b_ff);
      end else begin
         samp_raddr = cmd.samp_idx;
      end
      if (cmd.wr_a) begin
         samp_waddr = SAMP_W'(a_ff);
      end else if (cmd.wr_b) begin
         samp_waddr = SAMP_W'(b_ff);
      end else begin
         samp_waddr = cmd.samp_idx;
      end
   end

   assign wa_plus_t = wa_ff + WSUM_W'(t_ff);

   always_comb begin
      if (cmd.score_wr) begin
         weight_wdata = '0;
      end else if (cmd.wr_a) begin
         weight_wdata = wa_plus_t;
      end else if (a_ff == b_ff) begin
         // A pair naming one sample twice sees its own first update.
         weight_wdata = wa_plus_t - WSUM_W'(t_ff);
      end else begin
         weight_wdata = wb_ff - WSUM_W'(t_ff);
      end
   end

   assign weight_we = cmd.score_wr || cmd.wr_a || cmd.wr_b;

   rlg_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_SAMPLES)) u_score_ram (
      .clock (clock),
      .we    (cmd.score_wr),
      .waddr (samp_waddr),
      .wdata (sacc_in),
      .raddr (samp_raddr),
      .rdata (score_rdata)
   );

   rlg_ram #(.WIDTH(WSUM_W), .DEPTH(MAX_SAMPLES)) u_weight_ram (
      .clock (clock),
      .we    (weight_we),
      .waddr (samp_waddr),
      .wdata (weight_wdata),
      .raddr (samp_raddr),
      .rdata (weight_rdata)
   );

   // Score accumulation.
   assign sacc_in = (cmd.first ? SCORE_W'(0) : sacc_ff) + SCORE_W'(sprod_ff);

   always_ff @(posedge clock) begin
      if (cmd.score_mul) begin
         sprod_ff <= $signed(mat_rdata) * wv_ff[cmd.wv_idx];
      end
      if (cmd.score_acc) begin
         sacc_ff <= sacc_in;
      end
   end

   // Pair update: table index from the clamped score difference.
   assign diff = DIFF_W'(sa_ff) - DIFF_W'($signed(score_rdata));

   always_comb begin
      if (diff < -(DIFF_W'(1) <<< 27)) begin
         tab_idx = 8'd0;
      end else if (diff >= (DIFF_W'(1) <<< 27)) begin
         tab_idx = 8'd255;
      end else begin
         tab_idx = 8'((diff + (DIFF_W'(1) <<< 27)) >>> 20);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pair_latch) begin
         a_ff <= pair_rdata[PENT_W-1:SIDX_W];
         b_ff <= pair_rdata[SIDX_W-1:0];
      end
      if (cmd.sa_latch) begin
         sa_ff <= $signed(score_rdata);
         wa_ff <= weight_rdata;
      end
      if (cmd.t_calc) begin
         wb_ff <= weight_rdata;
         t_ff  <= SIG_TAB[tab_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (stat.run_start) begin
         used_ff <= '0;
      end else if (cmd.used_inc) begin
         used_ff <= used_ff + PCNT_W'(1);
      end
   end

   // Gradient accumulation and division by the used pair count.
   assign gacc_in = (cmd.first ? GACC_W'(0) : gacc_ff) + GACC_W'(gprod_ff);
   assign mag     = gacc_ff[GACC_W-1] ? (~gacc_ff + GACC_W'(1)) : gacc_ff;
   assign rem_sh  = {rem_ff, quot_ff[DIV_W-1]};
   assign rem_ge  = rem_sh >= REM_W'(used_ff);

   always_ff @(posedge clock) begin
      if (cmd.g_mul) begin
         gprod_ff <= $signed(weight_rdata) * $signed(mat_rdata);
      end
      if (cmd.g_acc) begin
         gacc_ff <= gacc_in;
      end
      if (cmd.div_init) begin
         quot_ff <= mag[GACC_W-1:FRAC_SH];
         rem_ff  <= '0;
         neg_ff  <= gacc_ff[GACC_W-1];
      end else if (cmd.div_step) begin
         rem_ff  <= rem_ge ? PCNT_W'(rem_sh - REM_W'(used_ff)) : rem_sh[PCNT_W-1:0];
         quot_ff <= {quot_ff[DIV_W-2:0], rem_ge};
      end
   end

   always_comb begin
      if (neg_ff) begin
         if (quot_ff > DIV_W'(33'h0_8000_0000)) begin
            grad_sat = 32'h8000_0000;
         end else begin
            grad_sat = ~quot_ff[GRAD_W-1:0] + GRAD_W'(1);
         end
      end else if (quot_ff > DIV_W'(32'h7FFF_FFFF)) begin
         grad_sat = 32'h7FFF_FFFF;
      end else begin
         grad_sat = quot_ff[GRAD_W-1:0];
      end
   end

   always_comb begin
      if (used_ff == '0) begin
         status_code = ST_NO_PAIRS;
      end else if (dropped_ff) begin
         status_code = ST_DROPPED;
      end else begin
         status_code = ST_OK;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_feature_ff <= FIDX_W'(cmd.out_feature);
         out_grad_ff    <= (used_ff == '0) ? GRAD_W'(0) : grad_sat;
         out_last_ff    <= cmd.out_last;
         out_status_ff  <= status_code;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.out_feature = out_feature_ff;
   assign rsp_bus.gradient    = out_grad_ff;
   assign rsp_bus.last        = out_last_ff;
   assign rsp_bus.status      = out_status_ff;

   assign stat.run_start  = accept && (req_bus.cmd == CMD_RUN);
   assign stat.ns         = ns;
   assign stat.nf         = nf;
   assign stat.pair_count = pair_count_ff;
   assign stat.pair_ok    = (32'(a_ff) < 32'(ns)) && (32'(b_ff) < 32'(ns));
   assign stat.out_free   = !out_valid_ff || rsp_bus.ready;

endmodule

>>> rtl/rlg_controller.sv
// Sequencer for the score, pair update, gradient, division and output phases of a run.
module rlg_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  rlg_pkg::ctl_stat_type stat,
   output rlg_pkg::ctl_cmd_type  cmd
);
   import rlg_pkg::*;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_SC_RD  = 5'd1;
   localparam logic [4:0] S_SC_MUL = 5'd2;
   localparam logic [4:0] S_SC_ACC = 5'd3;
   localparam logic [4:0] S_PR_RD  = 5'd4;
   localparam logic [4:0] S_PR_LAT = 5'd5;
   localparam logic [4:0] S_PR_SA  = 5'd6;
   localparam logic [4:0] S_PR_SB  = 5'd7;
   localparam logic [4:0] S_PR_T   = 5'd8;
   localparam logic [4:0] S_PR_WA  = 5'd9;
   localparam logic [4:0] S_PR_WB  = 5'd10;
   localparam logic [4:0] S_GR_RD  = 5'd11;
   localparam logic [4:0] S_GR_MUL = 5'd12;
   localparam logic [4:0] S_GR_ACC = 5'd13;
   localparam logic [4:0] S_DV_INI = 5'd14;
   localparam logic [4:0] S_DV_RUN = 5'd15;
   localparam logic [4:0] S_OUT    = 5'd16;

   logic [4:0]         state_ff, state_in;
   logic [SAMP_W-1:0]  i_ff, i_in;
   logic [FEAT_W-1:0]  f_ff, f_in;
   logic [PAIR_AW-1:0] p_ff, p_in;
   logic [DCNT_W-1:0]  cnt_ff, cnt_in;
   logic i_last, f_last, p_last;

   assign i_last = (SCNT_W'(i_ff) + SCNT_W'(1)) == stat.ns;
   assign f_last = (FCNT_W'(f_ff) + FCNT_W'(1)) == stat.nf;
   assign p_last = (PCNT_W'(p_ff) + PCNT_W'(1)) == stat.pair_count;

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      f_in     = f_ff;
      p_in     = p_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.mat_addr    = MAT_AW'(32'(i_ff) * MAX_FEATURES + 32'(f_ff));
      cmd.wv_idx      = f_ff;
      cmd.samp_idx    = i_ff;
      cmd.pair_addr   = p_ff;
      cmd.out_feature = f_ff;
      cmd.first       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            cmd.idle = 1'b1;
            if (stat.run_start) begin
               i_in     = '0;
               f_in     = '0;
               state_in = S_SC_RD;
            end
         end
         S_SC_RD: begin
            state_in = S_SC_MUL;
         end
         S_SC_MUL: begin
            cmd.score_mul = 1'b1;
            state_in      = S_SC_ACC;
         end
         S_SC_ACC: begin
            cmd.score_acc = 1'b1;
            cmd.first     = (f_ff == '0);
            if (f_last) begin
               cmd.score_wr = 1'b1;
               f_in         = '0;
               if (i_last) begin
                  i_in = '0;
                  p_in = '0;
                  state_in = (stat.pair_count == '0) ? S_GR_RD : S_PR_RD;
               end else begin
                  i_in     = i_ff + SAMP_W'(1);
                  state_in = S_SC_RD;
               end
            end else begin
               f_in     = f_ff + FEAT_W'(1);
               state_in = S_SC_RD;
            end
         end
         S_PR_RD: begin
            state_in = S_PR_LAT;
         end
         S_PR_LAT: begin
            cmd.pair_latch = 1'b1;
            state_in       = S_PR_SA;
         end
         S_PR_SA: begin
            cmd.rd_sel_a = 1'b1;
            if (stat.pair_ok) begin
               state_in = S_PR_SB;
            end else if (p_last) begin
               state_in = S_GR_RD;
            end else begin
               p_in     = p_ff + PAIR_AW'(1);
               state_in = S_PR_RD;
            end
         end
         S_PR_SB: begin
            cmd.sa_latch = 1'b1;
            cmd.rd_sel_b = 1'b1;
            state_in     = S_PR_T;
         end
         S_PR_T: begin
            cmd.t_calc = 1'b1;
            state_in   = S_PR_WA;
         end
         S_PR_WA: begin
            cmd.wr_a = 1'b1;
            state_in = S_PR_WB;
         end
         S_PR_WB: begin
            cmd.wr_b     = 1'b1;
            cmd.used_inc = 1'b1;
            if (p_last) begin
               state_in = S_GR_RD;
            end else begin
               p_in     = p_ff + PAIR_AW'(1);
               state_in = S_PR_RD;
            end
         end
         S_GR_RD: begin
            state_in = S_GR_MUL;
         end
         S_GR_MUL: begin
            cmd.g_mul = 1'b1;
            state_in  = S_GR_ACC;
         end
         S_GR_ACC: begin
            cmd.g_acc = 1'b1;
            cmd.first = (i_ff == '0);
            if (i_last) begin
               state_in = S_DV_INI;
            end else begin
               i_in     = i_ff + SAMP_W'(1);
               state_in = S_GR_RD;
            end
         end
         S_DV_INI: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = S_DV_RUN;
         end
         S_DV_RUN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + DCNT_W'(1);
            if (cnt_ff == DCNT_W'(DIV_W - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            cmd.out_last = f_last;
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               i_in         = '0;
               if (f_last) begin
                  f_in     = '0;
                  state_in = S_IDLE;
               end else begin
                  f_in     = f_ff + FEAT_W'(1);
                  state_in = S_GR_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         i_ff     <= '0;
         f_ff     <= '0;
         p_ff     <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         f_ff     <= f_in;
         p_ff     <= p_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> rtl/ranking_logistic_gradient.sv
// Top level of the pairwise ranking logistic-loss gradient engine.
// Load, pair and clear transactions are accepted one per cycle while the sequencer is idle.
// A run walks the matrix RAM through the score and gradient multipliers, then divides each
// feature sum by the used pair count with the one-bit-per-cycle divider.
// Results leave through an output register, so the next transaction is taken while one waits.
// Synchronous active-high reset clears control, pair count, drop flag and result valid.
module ranking_logistic_gradient (
   input logic clock,
   input logic reset,
   rlg_req_if.sink   req_bus,
   rlg_rsp_if.source rsp_bus,
   rlg_csr_if.sink   csr_bus
);
   import rlg_pkg::*;

   // Command and status buses between the sequencer and the datapath.
   ctl_cmd_type  ctl_cmd;
   ctl_stat_type ctl_stat;

   // The sequencer walks the scores, the pair list, the per-feature sums and the divider.
   rlg_controller u_ctl (
      .clock (clock),
      .reset (reset),
      .stat  (ctl_stat),
      .cmd   (ctl_cmd)
   );

   // The datapath holds all stores, the arithmetic and the result register.
   rlg_datapath u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus),
      .cmd     (ctl_cmd),
      .stat    (ctl_stat)
   );

endmodule

>>> bench/rlg_gradient_checker.sv
// Checker for the ranking gradient engine: predicts every gradient result and compares it.
`timescale 1ns / 1ps

module rlg_gradient_checker (
   input  logic clock,
   input  logic reset,
   rlg_req_if   req_ch,
   rlg_rsp_if   rsp_ch,
   rlg_csr_if   csr_ch,
   output int   fail_count,
   output int   pending
);
   import rlg_pkg::*;

   typedef struct {
      logic [FIDX_W-1:0]        feature;
      logic signed [GRAD_W-1:0] grad;
      logic                     last;
      logic [STAT_W-1:0]        status;
   } grad_result_type;

   grad_result_type grad_expect [$];

   logic signed [VAL_W-1:0] matrix_copy [MAX_SAMPLES][MAX_FEATURES];
   logic signed [VAL_W-1:0] weight_copy [MAX_FEATURES];
   logic [SIDX_W-1:0]       lower_copy  [MAX_PAIRS];
   logic [SIDX_W-1:0]       upper_copy  [MAX_PAIRS];
   int unsigned             stored_pairs;
   bit                      drop_flag;
   int unsigned             samples_reg;
   int unsigned             features_reg;
   int                      sigmoid_lut [256];

   // The sigmoid at each bin center, rounded to Q0.16.
   initial begin
      for (int k = 0; k < 256; k++) begin
         sigmoid_lut[k] = int'($floor(65536.0 / (1.0 + $exp(-(k - 127.5) / 16.0)) + 0.5));
      end
   end

   task automatic predict_gradients();
      longint       score [MAX_SAMPLES];
      longint       wsum  [MAX_SAMPLES];
      longint       lim, d, acc, g;
      int unsigned  nsv, nfv, used, a, b, k;
      grad_result_type r;
      lim  = longint'(8) <<< 24;
      nsv  = (samples_reg == 0) ? 1 : ((samples_reg > MAX_SAMPLES) ? MAX_SAMPLES : samples_reg);
      nfv  = (features_reg == 0) ? 1 : ((features_reg > NF_LIMIT) ? NF_LIMIT : features_reg);
      used = 0;
      for (int i = 0; i < nsv; i++) begin
         acc = 0;
         for (int f = 0; f < nfv; f++) begin
            acc += longint'(matrix_copy[i][f]) * longint'(weight_copy[f]);
         end
         score[i] = acc;
         wsum[i]  = 0;
      end
      for (int p = 0; p < stored_pairs; p++) begin
         a = 32'(lower_copy[p]);
         b = 32'(upper_copy[p]);
         if (a < nsv && b < nsv) begin
            d = score[a] - score[b];
            if (d < -lim) k = 0;
            else if (d >= lim) k = 255;
            else k = int'((d + lim) >>> 20);
            wsum[a] += sigmoid_lut[k];
            wsum[b] -= sigmoid_lut[k];
            used++;
         end
      end
      r.status = (used == 0) ? ST_NO_PAIRS : (drop_flag ? ST_DROPPED : ST_OK);
      for (int f = 0; f < nfv; f++) begin
         g = 0;
         if (used != 0) begin
            acc = 0;
            for (int i = 0; i < nsv; i++) begin
               acc += wsum[i] * longint'(matrix_copy[i][f]);
            end
            g = acc / (longint'(used) * 4096);
            if (g > 64'sd2147483647) g = 64'sd2147483647;
            if (g < -64'sd2147483648) g = -64'sd2147483648;
         end
         r.feature = FIDX_W'(f);
         r.grad    = GRAD_W'(g);
         r.last    = (f + 1 == nfv);
         grad_expect.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      grad_result_type e;
      if (reset) begin
         stored_pairs = 0;
         drop_flag    = 0;
         samples_reg  = MAX_SAMPLES;
         features_reg = NF_LIMIT;
         fail_count   = 0;
         grad_expect.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == CSR_NUM_SAMPLES) samples_reg = 32'(csr_ch.data);
            else features_reg = 32'(csr_ch.data & 7'h1F);
         end
         if (req_ch.valid && req_ch.ready) begin
            case (req_ch.cmd)
               CMD_LOAD_MATRIX: begin
                  matrix_copy[req_ch.sample_index][req_ch.feature_index] = req_ch.value;
               end
               CMD_LOAD_WEIGHT: begin
                  weight_copy[req_ch.feature_index] = req_ch.value;
               end
               CMD_ADD_PAIR: begin
                  if (stored_pairs < MAX_PAIRS) begin
                     lower_copy[stored_pairs] = req_ch.sample_index;
                     upper_copy[stored_pairs] = req_ch.larger_index;
                     stored_pairs++;
                  end else begin
                     drop_flag = 1;
                  end
               end
               CMD_CLEAR_PAIRS: begin
                  stored_pairs = 0;
                  drop_flag    = 0;
               end
               CMD_RUN: begin
                  predict_gradients();
               end
               default: begin
               end
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (grad_expect.size() == 0) begin
               $error("unexpected result: out_feature %0d gradient %0d", rsp_ch.out_feature,
                      rsp_ch.gradient);
               fail_count++;
            end else begin
               e = grad_expect.pop_front();
               if (rsp_ch.out_feature !== e.feature) begin
                  $error("out_feature: expected %0d, actual %0d", e.feature, rsp_ch.out_feature);
                  fail_count++;
               end
               if (rsp_ch.gradient !== e.grad) begin
                  $error("gradient: expected %0d, actual %0d", e.grad, rsp_ch.gradient);
                  fail_count++;
               end
               if (rsp_ch.last !== e.last) begin
                  $error("last: expected %0d, actual %0d", e.last, rsp_ch.last);
                  fail_count++;
               end
               if (rsp_ch.status !== e.status) begin
                  $error("status: expected %0d, actual %0d", e.status, rsp_ch.status);
                  fail_count++;
               end
            end
         end
      end
      pending = grad_expect.size();
   end

endmodule

>>> bench/ranking_logistic_gradient_test.sv
// Top of the ranking gradient bench: clock, reset, stimulus, stalls and the verdict.
`timescale 1ns / 1ps

module ranking_logistic_gradient_test;
   import rlg_pkg::*;

   // Cycles without any transaction on any channel before the run is declared hung.
   localparam int IDLE_LIMIT = 60000;
   localparam int HOLD_CYCLES = 400;
   // Matrix rows that are loaded in every column; other rows hold column 0 only.
   localparam int ROWS_FULL = 8;
   localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;
   localparam logic [VAL_W-1:0] VAL_ZERO = '0;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   idle_cycles;
   int   gap_max;
   int   active_samples;
   bit   hold_results;

   rlg_req_if req_bus ();
   rlg_rsp_if rsp_bus ();
   rlg_csr_if csr_bus ();

   ranking_logistic_gradient dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   rlg_gradient_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_bus),
      .rsp_ch     (rsp_bus),
      .csr_ch     (csr_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 0;
   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // The watchdog restarts its count whenever any channel completes a transaction.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[ranking_logistic_gradient] ERROR");
            $finish;
         end
      end
   end

   // Result receiver. It stalls a random number of cycles before every result, and once
   // holds off for a long stretch so that the output register and the input back up.
   initial begin
      int stall;
      rsp_bus.ready = 0;
      forever begin
         if (hold_results) begin
            rsp_bus.ready <= 0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_results = 0;
         end
         stall = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // Sends one command transaction. It returns at the edge that accepted it with valid
   // still high, so the next call may follow with no gap in the same time step.
   task automatic send_cmd(input logic [CMD_W-1:0] cmd, input int si, input int fi,
                           input int li, input logic [VAL_W-1:0] val);
      int gap;
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
         req_bus.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1;
      req_bus.cmd           <= cmd;
      req_bus.sample_index  <= SIDX_W'(si);
      req_bus.feature_index <= FIDX_W'(fi);
      req_bus.larger_index  <= SIDX_W'(li);
      req_bus.value         <= val;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Lowers the command valid and waits until every predicted result has been seen.
   // The first wait lets the checker book a run accepted at the current edge.
   task automatic drain_results();
      req_bus.valid <= 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Register writes happen only with the engine drained.
   task automatic write_reg(input logic [CSR_IW-1:0] idx, input int data);
      drain_results();
      csr_bus.valid <= 1;
      csr_bus.index <= idx;
      csr_bus.data  <= CSR_DW'(data);
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 0;
      if (idx == CSR_NUM_SAMPLES) begin
         active_samples = (data == 0) ? 1 : ((data > MAX_SAMPLES) ? MAX_SAMPLES : data);
      end
   endtask

   // Mostly small values so that score differences land across the whole sigmoid range,
   // with full-range values and the two extremes mixed in.
   function automatic logic [VAL_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return VAL_W'($urandom_range(0, 2047) - 1024);
      if (r < 85) return VAL_W'($urandom);
      return (r < 92) ? 16'h8000 : 16'h7FFF;
   endfunction

   function automatic int pick_sample();
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, active_samples - 1);
      return $urandom_range(0, 63);
   endfunction

   task automatic send_random_cmd();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) begin
         send_cmd(CMD_LOAD_MATRIX, $urandom_range(0, 63), $urandom_range(0, 15),
                  $urandom_range(0, 63), pick_value());
      end else if (r < 35) begin
         send_cmd(CMD_LOAD_WEIGHT, $urandom_range(0, 63), $urandom_range(0, 15),
                  $urandom_range(0, 63), pick_value());
      end else if (r < 80) begin
         send_cmd(CMD_ADD_PAIR, pick_sample(), $urandom_range(0, 15), pick_sample(),
                  VAL_W'($urandom));
      end else if (r < 84) begin
         send_cmd(CMD_CLEAR_PAIRS, $urandom_range(0, 63), $urandom_range(0, 15),
                  $urandom_range(0, 63), VAL_W'($urandom));
      end else if (r < 96) begin
         send_cmd(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 15),
                  $urandom_range(0, 63), VAL_W'($urandom));
      end else begin
         send_cmd(CMD_W'(CMD_UNKNOWN_LO
                         + $urandom_range(0, CMD_UNKNOWN_HI - CMD_UNKNOWN_LO)),
                  $urandom_range(0, 63), $urandom_range(0, 15), $urandom_range(0, 63),
                  VAL_W'($urandom));
      end
   endtask

   initial begin
      req_bus.valid         = 0;
      req_bus.cmd           = CMD_LOAD_MATRIX;
      req_bus.sample_index  = 0;
      req_bus.feature_index = 0;
      req_bus.larger_index  = 0;
      req_bus.value         = 0;
      csr_bus.valid         = 0;
      csr_bus.index         = CSR_NUM_SAMPLES;
      csr_bus.data          = 0;
      hold_results          = 0;
      gap_max               = 0;
      active_samples        = MAX_SAMPLES;
      idle_cycles           = 0;
      reset                 = 1;
      repeat (5) @(posedge clock);
      reset <= 0;

      // Rows below ROWS_FULL get every column and the other rows column 0 only. Runs keep
      // the sample count at or below ROWS_FULL unless a single feature is in use, so no run
      // ever reads an unwritten entry.
      for (int s = 0; s < MAX_SAMPLES; s++) begin
         for (int f = 0; f < MAX_FEATURES; f++) begin
            if (s < ROWS_FULL || f == 0) begin
               send_cmd(CMD_LOAD_MATRIX, s, f, 0, pick_value());
            end
         end
      end
      for (int f = 0; f < MAX_FEATURES; f++) begin
         send_cmd(CMD_LOAD_WEIGHT, 0, f, 0, pick_value());
      end
      write_reg(CSR_NUM_SAMPLES, ROWS_FULL);

      // A run with no pairs stored must give all-zero gradients with the no-pairs status.
      send_cmd(CMD_RUN, 0, 0, 0, VAL_ZERO);
      // Extreme matrix and weight values drive score differences past both clamp edges.
      send_cmd(CMD_LOAD_MATRIX, ROWS_FULL - 1, 15, 0, 16'h8000);
      send_cmd(CMD_LOAD_MATRIX, 0, 0, 0, 16'h7FFF);
      send_cmd(CMD_LOAD_WEIGHT, 0, 15, 0, 16'h7FFF);
      send_cmd(CMD_LOAD_WEIGHT, 0, 0, 0, 16'h8000);
      send_cmd(CMD_ADD_PAIR, 0, 0, ROWS_FULL - 1, VAL_ZERO);
      send_cmd(CMD_ADD_PAIR, ROWS_FULL - 1, 0, 0, VAL_ZERO);
      send_cmd(CMD_ADD_PAIR, 5, 0, 5, VAL_ZERO);
      send_cmd(CMD_ADD_PAIR, 1, 0, ROWS_FULL - 2, VAL_ZERO);
      // Unknown commands are ignored and cause nothing.
      send_cmd(CMD_UNKNOWN_LO, 63, 15, 63, 16'hFFFF);
      send_cmd(CMD_UNKNOWN_HI, 0, 0, 0, VAL_ZERO);
      send_cmd(CMD_RUN, 63, 15, 63, 16'hFFFF);

      // Only sample 0 in use: pairs that reach beyond it are skipped, and a single feature.
      write_reg(CSR_NUM_SAMPLES, 1);
      write_reg(CSR_NUM_FEATURES, 1);
      send_cmd(CMD_RUN, 0, 0, 0, VAL_ZERO);
      send_cmd(CMD_ADD_PAIR, 0, 0, 0, VAL_ZERO);
      send_cmd(CMD_RUN, 0, 0, 0, VAL_ZERO);
      // Zero acts as one, and values past the maximum saturate.
      write_reg(CSR_NUM_SAMPLES, 0);
      write_reg(CSR_NUM_FEATURES, 0);
      send_cmd(CMD_RUN, 0, 0, 0, VAL_ZERO);
      write_reg(CSR_NUM_SAMPLES, 127);
      send_cmd(CMD_RUN, 0, 0, 0, VAL_ZERO);
      write_reg(CSR_NUM_SAMPLES, 1);
      write_reg(CSR_NUM_FEATURES, 31);
      send_cmd(CMD_RUN, 0, 0, 0, VAL_ZERO);
      write_reg(CSR_NUM_SAMPLES, ROWS_FULL);
      write_reg(CSR_NUM_FEATURES, 16);

      // Overfill the pair store: the excess is dropped and flagged until pairs are cleared.
      for (int p = 0; p < MAX_PAIRS + 1; p++) begin
         send_cmd(CMD_ADD_PAIR, $urandom_range(0, 63), 0, $urandom_range(0, 63), VAL_ZERO);
      end
      send_cmd(CMD_RUN, 0, 0, 0, VAL_ZERO);
      send_cmd(CMD_CLEAR_PAIRS, 0, 0, 0, VAL_ZERO);
      send_cmd(CMD_RUN, 0, 0, 0, VAL_ZERO);

      // Random phases, each with its own register setting and idling pattern.
      for (int phase = 0; phase < 3; phase++) begin
         write_reg(CSR_NUM_SAMPLES, (phase == 0) ? ROWS_FULL : $urandom_range(0, ROWS_FULL));
         write_reg(CSR_NUM_FEATURES, (phase == 0) ? 16 : $urandom_range(0, 31));
         gap_max = (phase % 2 == 0) ? 16 : 0;
         send_cmd(CMD_CLEAR_PAIRS, 0, 0, 0, VAL_ZERO);
         if (phase == 1) begin
            // Long receiver hold-off while runs keep arriving back to back.
            hold_results = 1;
            for (int n = 0; n < 6; n++) begin
               send_cmd(CMD_ADD_PAIR, pick_sample(), 0, pick_sample(), VAL_ZERO);
               send_cmd(CMD_RUN, 0, 0, 0, VAL_ZERO);
            end
         end
         for (int n = 0; n < 25; n++) begin
            send_random_cmd();
         end
         send_cmd(CMD_RUN, 0, 0, 0, VAL_ZERO);
      end

      drain_results();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("[ranking_logistic_gradient] OK");
      end else begin
         $display("[ranking_logistic_gradient] ERROR");
      end
      $finish;
   end

endmodule
